// ----- hw/rtl/nta_pkg.sv -----
package nta_pkg;

  // format codes carried in the action field
  localparam logic [2:0] ACT_BIN8 = 3'd0;
  localparam logic [2:0] ACT_HEX2 = 3'd1;
  localparam logic [2:0] ACT_DEC2 = 3'd2;
  localparam logic [2:0] ACT_DEC3 = 3'd3;
  localparam logic [2:0] ACT_DEC5 = 3'd4;

  // character codes
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_ONE  = 8'h31;
  localparam logic [7:0] ASCII_E    = 8'h45;
  localparam logic [7:0] ASCII_R    = 8'h72;
  localparam logic [7:0] HEX_GAP    = 8'd7;

  // range limits for the fixed-width decimal formats
  localparam logic [15:0] DEC2_LIMIT = 16'd100;
  localparam logic [15:0] DEC3_LIMIT = 16'd1000;

  // decimal place index: 10000, 1000, 100, 10, 1
  typedef logic [2:0] widx_t;
  localparam widx_t WIDX_10K  = 3'd0;
  localparam widx_t WIDX_1K   = 3'd1;
  localparam widx_t WIDX_100  = 3'd2;
  localparam widx_t WIDX_10   = 3'd3;
  localparam widx_t WIDX_ONES = 3'd4;

  // one character on its way to the output register
  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last;
  } char_t;

  // weight of a decimal place
  function automatic logic [13:0] dec_weight(input widx_t idx);
    logic [13:0] w;
    case (idx)
      WIDX_10K: w = 14'd10000;
      WIDX_1K:  w = 14'd1000;
      WIDX_100: w = 14'd100;
      WIDX_10:  w = 14'd10;
      default:  w = 14'd1;
    endcase
    return w;
  endfunction

  // uppercase hex character of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    c = {4'h0, nib} + ASCII_ZERO;
    if (nib > 4'd9) begin
      c = c + HEX_GAP;
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/nta_if.sv -----
// input channel: format code and value
interface nta_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

// result channel: one character per item
interface nta_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

// ----- hw/rtl/nta_digit_unit.sv -----
// Shared compare/subtract unit: remainder minus the weight of one decimal place.
module nta_digit_unit import nta_pkg::*; (
  input  logic [15:0] rem,
  input  widx_t       widx,
  output logic        ge,
  output logic [15:0] diff
);

  logic [16:0] sub;

  // borrow out clear means rem >= weight
  assign sub  = {1'b0, rem} - {3'b000, dec_weight(widx)};
  assign ge   = ~sub[16];
  assign diff = sub[15:0];

endmodule

// ----- hw/rtl/nta_out_stage.sv -----
// Output register: holds one character until the receiver takes it.
module nta_out_stage import nta_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  char_t     din,
  output logic      can_push,
  nta_out_if.source out_ch
);

  logic  valid_r;
  char_t data_r;

  // room when empty or when the held item leaves this cycle
  assign can_push = ~valid_r | out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= din;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.ascii_char = data_r.ascii_char;
  assign out_ch.last       = data_r.last;

endmodule

// ----- hw/rtl/number_to_ascii_formatter.sv -----
// Number to ASCII formatter.
// in_ch takes one item: a 3-bit format code and a 16-bit value. out_ch returns
// the formatted text one character per item, last set on the final character.
// Formats: 8 binary digits or 2 hex digits of the low byte, 2 or 3 decimal
// digits with leading zeros (or "Err" when out of range), and 1 to 5 decimal
// digits with leading zeros suppressed. Codes 5 to 7 are taken and dropped.
// Binary, hex and "Err" text emit one character per cycle while the receiver takes them.
// Decimal digits come from one compare/subtract unit, one subtraction of the
// place weight per cycle: a digit above the ones place counts subtractions
// while the remainder covers the weight, then goes out; the ones digit is taken
// from the remainder as is, and a suppressed leading zero only moves on a place.
// The first character is pushed from the text state for binary, hex and "Err"
// text, and from the digit state after the divide state for decimal formats.
// in_ch.ready is high only while no item is in progress.
// A stalled receiver holds the character in the output register and the
// sequencer waits; nothing is lost. Synchronous reset (rst_n low) drops any
// item in progress and empties the output register.
module number_to_ascii_formatter import nta_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  nta_in_if.sink   in_ch,
  nta_out_if.source out_ch
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DEC  = 2'd2;
  localparam logic [1:0] S_TXT  = 2'd3;

  logic [1:0]  state_r,   state_nxt;
  logic [2:0]  mode_r,    mode_nxt;
  logic [15:0] rem_r,     rem_nxt;
  logic [7:0]  sh_r,      sh_nxt;
  widx_t       widx_r,    widx_nxt;
  logic [3:0]  digit_r,   digit_nxt;
  logic        started_r, started_nxt;
  logic [2:0]  cnt_r,     cnt_nxt;
  logic [2:0]  total_r,   total_nxt;
  logic        err_r,     err_nxt;

  logic        ge;
  logic [15:0] diff;
  logic        can_push;
  logic        push;
  char_t       ch;

  nta_digit_unit u_digit (
    .rem  (rem_r),
    .widx (widx_r),
    .ge   (ge),
    .diff (diff)
  );

  nta_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .din      (ch),
    .can_push (can_push),
    .out_ch   (out_ch)
  );

  assign in_ch.ready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    rem_nxt     = rem_r;
    sh_nxt      = sh_r;
    widx_nxt    = widx_r;
    digit_nxt   = digit_r;
    started_nxt = started_r;
    cnt_nxt     = cnt_r;
    total_nxt   = total_r;
    err_nxt     = err_r;
    push        = 1'b0;
    ch          = '0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt    = in_ch.action;
          rem_nxt     = in_ch.value;
          sh_nxt      = in_ch.value[7:0];
          digit_nxt   = 4'd0;
          started_nxt = 1'b0;
          cnt_nxt     = 3'd0;
          err_nxt     = 1'b0;
          case (in_ch.action)
            ACT_BIN8: begin
              total_nxt = 3'd7;
              state_nxt = S_TXT;
            end
            ACT_HEX2: begin
              total_nxt = 3'd1;
              state_nxt = S_TXT;
            end
            ACT_DEC2: begin
              if (in_ch.value >= DEC2_LIMIT) begin
                err_nxt   = 1'b1;
                total_nxt = 3'd2;
                state_nxt = S_TXT;
              end else begin
                widx_nxt  = WIDX_10;
                state_nxt = S_DIV;
              end
            end
            ACT_DEC3: begin
              if (in_ch.value >= DEC3_LIMIT) begin
                err_nxt   = 1'b1;
                total_nxt = 3'd2;
                state_nxt = S_TXT;
              end else begin
                widx_nxt  = WIDX_100;
                state_nxt = S_DIV;
              end
            end
            ACT_DEC5: begin
              widx_nxt  = WIDX_10K;
              state_nxt = S_DIV;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // one subtraction of the place weight per cycle; ones digit taken as is
      S_DIV: begin
        if (widx_r == WIDX_ONES) begin
          digit_nxt = rem_r[3:0];
          state_nxt = S_DEC;
        end else if (ge) begin
          rem_nxt   = diff;
          digit_nxt = digit_r + 4'd1;
        end else if (mode_r == ACT_DEC5 && !started_r && digit_r == 4'd0) begin
          // leading zero suppressed: move to next place
          widx_nxt = widx_r + 3'd1;
        end else begin
          state_nxt = S_DEC;
        end
      end

      // emit one decimal digit
      S_DEC: begin
        ch.ascii_char = ASCII_ZERO + {4'h0, digit_r};
        ch.last       = (widx_r == WIDX_ONES);
        if (can_push) begin
          push        = 1'b1;
          started_nxt = 1'b1;
          digit_nxt   = 4'd0;
          if (ch.last) begin
            state_nxt = S_IDLE;
          end else begin
            widx_nxt  = widx_r + 3'd1;
            state_nxt = S_DIV;
          end
        end
      end

      // binary, hex and error text
      S_TXT: begin
        if (err_r) begin
          ch.ascii_char = (cnt_r == 3'd0) ? ASCII_E : ASCII_R;
        end else if (mode_r == ACT_HEX2) begin
          ch.ascii_char = hex_char(sh_r[7:4]);
        end else begin
          ch.ascii_char = sh_r[7] ? ASCII_ONE : ASCII_ZERO;
        end
        ch.last = (cnt_r == total_r);
        if (can_push) begin
          push    = 1'b1;
          cnt_nxt = cnt_r + 3'd1;
          sh_nxt  = (mode_r == ACT_HEX2) ? {sh_r[3:0], 4'h0} : {sh_r[6:0], 1'b0};
          if (ch.last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    rem_r     <= rem_nxt;
    sh_r      <= sh_nxt;
    widx_r    <= widx_nxt;
    digit_r   <= digit_nxt;
    started_r <= started_nxt;
    cnt_r     <= cnt_nxt;
    total_r   <= total_nxt;
    err_r     <= err_nxt;
  end

endmodule

// ----- hw/rtl/nta_checker.sv -----
// Port-level checks on the formatter.
module nta_checker import nta_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] in_action,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_ascii_char,
  input logic       out_last
);

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ascii_char) && $stable(out_last))
    else $error("output item changed while stalled");

  // a formatted item keeps the block busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action <= ACT_DEC5 |=> !in_ready)
    else $error("ready after taking a formatted item");

  // an unused format code is dropped at once
  a_drop_unused: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action > ACT_DEC5 |=> in_ready)
    else $error("unused format code stalled the input");

  // a non-final character on the output means the item is still in progress
  a_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("ready before the final character");

endmodule

bind number_to_ascii_formatter nta_checker u_nta_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_action      (in_ch.action),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_ascii_char (out_ch.ascii_char),
  .out_last       (out_ch.last)
);

// ----- sim/tb_number_to_ascii_formatter.sv -----
module tb_number_to_ascii_formatter;
  import nta_pkg::*;

  // format codes the block takes and drops
  localparam logic [2:0] ACT_SPARE5 = 3'd5;
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int LONG_HOLD = 250;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 270;
  localparam int PHASE_ITEMS = 40;

  logic clk = 1'b0;
  logic rst_n;

  nta_in_if in_ch();
  nta_out_if out_ch();

  number_to_ascii_formatter uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // characters still owed by the block, oldest first
  char_t pending_chars[$];
  char_t oldest_char;

  int mismatches = 0;
  int chars_seen = 0;
  int numbers_sent = 0;
  int cycle_count = 0;
  int in_stall_cycles = 0;
  int fmt_count[8];

  // pacing controls
  bit tx_gaps_on = 1'b0;
  bit rx_stalls_on = 1'b0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int rx_left = 0;

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    else if (r < 95) return $urandom_range(3, 8);
    else return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // work out the text for one number and queue its characters
  function automatic void predict_text(input logic [2:0] fmt, input logic [15:0] num);
    char_t text[$];
    char_t c;
    logic [7:0] lo;
    logic [3:0] nib;
    logic [15:0] place;
    logic [15:0] digit;
    bit leading;
    lo = num[7:0];
    c.last = 1'b0;
    case (fmt)
      ACT_BIN8: begin
        for (int i = 7; i >= 0; i--) begin
          c.ascii_char = lo[i] ? ASCII_ONE : ASCII_ZERO;
          text.push_back(c);
        end
      end
      ACT_HEX2: begin
        for (int i = 1; i >= 0; i--) begin
          nib = lo[i*4 +: 4];
          c.ascii_char = (nib < 4'd10) ? ASCII_ZERO + {4'h0, nib}
                                       : ASCII_UPPER_A + {4'h0, nib} - 8'd10;
          text.push_back(c);
        end
      end
      ACT_DEC2, ACT_DEC3: begin
        if ((fmt == ACT_DEC2 && num >= DEC2_LIMIT) || (fmt == ACT_DEC3 && num >= DEC3_LIMIT)) begin
          c.ascii_char = ASCII_E;
          text.push_back(c);
          c.ascii_char = ASCII_R;
          text.push_back(c);
          text.push_back(c);
        end else begin
          place = (fmt == ACT_DEC2) ? 16'd10 : 16'd100;
          while (place != 16'd0) begin
            digit = (num / place) % 16'd10;
            c.ascii_char = ASCII_ZERO + digit[7:0];
            text.push_back(c);
            place = place / 16'd10;
          end
        end
      end
      ACT_DEC5: begin
        // leading zeros dropped, ones place always printed
        leading = 1'b1;
        place = 16'd10000;
        while (place != 16'd0) begin
          digit = (num / place) % 16'd10;
          if (digit != 16'd0 || !leading || place == 16'd1) begin
            c.ascii_char = ASCII_ZERO + digit[7:0];
            text.push_back(c);
            leading = 1'b0;
          end
          place = place / 16'd10;
        end
      end
      default: ;
    endcase
    if (text.size() > 0) text[text.size()-1].last = 1'b1;
    foreach (text[i]) pending_chars.push_back(text[i]);
  endfunction

  // offer one item, return once it is taken (valid left high)
  task automatic send_number(input logic [2:0] fmt, input logic [15:0] num);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= fmt;
    in_ch.value <= num;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_text(fmt, num);
    fmt_count[fmt]++;
    numbers_sent++;
  endtask

  // receiver pacing: random stalls, plus a long hold on request
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!rx_stalls_on) begin
      out_ch.ready <= 1'b1;
    end else if (rx_left > 0) begin
      rx_left <= rx_left - 1;
    end else if (!out_ch.ready) begin
      out_ch.ready <= 1'b1;
      rx_left <= $urandom_range(0, 12);
    end else begin
      out_ch.ready <= 1'b0;
      rx_left <= pick_gap();
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                  out_ch.ascii_char, out_ch.last));
      end else begin
        oldest_char = pending_chars.pop_front();
        if (out_ch.ascii_char !== oldest_char.ascii_char)
          report_mismatch($sformatf("ascii_char 0x%02h, wanted 0x%02h",
                                    out_ch.ascii_char, oldest_char.ascii_char));
        if (out_ch.last !== oldest_char.last)
          report_mismatch($sformatf("last %0b, wanted %0b on char 0x%02h",
                                    out_ch.last, oldest_char.last, oldest_char.ascii_char));
      end
    end
  end

  // cycle count, input stall count and timeout
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && in_ch.valid && !in_ch.ready) in_stall_cycles++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d chars outstanding",
               cycle_count, pending_chars.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_binary_format();
    send_number(ACT_BIN8, 16'h0000);
    send_number(ACT_BIN8, 16'h00FF);
    send_number(ACT_BIN8, 16'hFF5A);
    send_number(ACT_BIN8, 16'h00A5);
  endtask

  task automatic test_hex_format();
    send_number(ACT_HEX2, 16'h0000);
    send_number(ACT_HEX2, 16'h00FF);
    send_number(ACT_HEX2, 16'h129A);
    send_number(ACT_HEX2, 16'hFF09);
  endtask

  // leading zeros and the out-of-range text
  task automatic test_fixed_decimal();
    send_number(ACT_DEC2, 16'd0);
    send_number(ACT_DEC2, 16'd99);
    send_number(ACT_DEC2, 16'd100);
    send_number(ACT_DEC2, 16'd65535);
    send_number(ACT_DEC3, 16'd0);
    send_number(ACT_DEC3, 16'd7);
    send_number(ACT_DEC3, 16'd999);
    send_number(ACT_DEC3, 16'd1000);
    send_number(ACT_DEC3, 16'd65535);
  endtask

  // zero prints one char; inner zeros must stay
  task automatic test_suppressed_decimal();
    send_number(ACT_DEC5, 16'd0);
    send_number(ACT_DEC5, 16'd9);
    send_number(ACT_DEC5, 16'd10);
    send_number(ACT_DEC5, 16'd10005);
    send_number(ACT_DEC5, 16'd65535);
  endtask

  // dropped codes, then a normal item to show nothing leaked
  task automatic test_unused_codes();
    send_number(ACT_SPARE5, 16'd1234);
    send_number(ACT_SPARE6, 16'hFFFF);
    send_number(ACT_SPARE7, 16'h0000);
    send_number(ACT_BIN8, 16'h0081);
  endtask

  function automatic logic [15:0] pick_value();
    logic [15:0] corners[10] = '{16'd0, 16'd9, 16'd10, 16'd99, 16'd100,
                                 16'd999, 16'd1000, 16'd9999, 16'd10000, 16'd65535};
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 99));
      2: return 16'($urandom_range(0, 999));
      default: return corners[$urandom_range(0, 9)];
    endcase
  endfunction

  function automatic logic [2:0] pick_format();
    if ($urandom_range(0, 19) == 0) return 3'($urandom_range(5, 7));
    return 3'($urandom_range(0, 4));
  endfunction

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure_fill();
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    hold_requests++;
    for (int i = 0; i < 12; i++) send_number(3'($urandom_range(0, 4)), pick_value());
  endtask

  task automatic test_random_items();
    int counted;
    logic [2:0] fmt;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      // new pacing mix every phase, sometimes with no idling at all
      if (counted % PHASE_ITEMS == 0) begin
        tx_gaps_on = 1'($urandom_range(0, 1));
        rx_stalls_on = 1'($urandom_range(0, 1));
      end
      fmt = pick_format();
      send_number(fmt, pick_value());
      if (fmt <= ACT_DEC5) counted++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_BIN8;
    in_ch.value = 16'h0000;
    out_ch.ready = 1'b0;
    foreach (fmt_count[i]) fmt_count[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_binary_format();
    test_hex_format();
    test_fixed_decimal();
    test_suppressed_decimal();
    test_unused_codes();
    test_backpressure_fill();
    test_random_items();
    in_ch.valid <= 1'b0;

    // drain, then give the block time to show any stray output
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0)
      report_mismatch($sformatf("%0d chars never arrived", pending_chars.size()));

    $display("Formatted %0d numbers: bin8 %0d, hex2 %0d, dec2 %0d, dec3 %0d, dec5 %0d, dropped %0d",
             numbers_sent, fmt_count[ACT_BIN8], fmt_count[ACT_HEX2], fmt_count[ACT_DEC2],
             fmt_count[ACT_DEC3], fmt_count[ACT_DEC5],
             fmt_count[ACT_SPARE5] + fmt_count[ACT_SPARE6] + fmt_count[ACT_SPARE7]);
    $display("%0d chars checked, input stalled %0d cycles, %0d mismatches",
             chars_seen, in_stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/nta_pkg.sv
hw/rtl/nta_if.sv
hw/rtl/nta_digit_unit.sv
hw/rtl/nta_out_stage.sv
hw/rtl/number_to_ascii_formatter.sv
hw/rtl/nta_checker.sv
sim/tb_number_to_ascii_formatter.sv
